// ===== rtl/ali_pkg.sv =====
// shared constants, codes and types for the array list block
`timescale 1ns / 1ps

package ali_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    // compare width: holds both count and position with a spare bit for idx + 1
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] FN_INSERT   = 3'd0;
    localparam logic [2:0] FN_APPEND   = 3'd1;
    localparam logic [2:0] FN_DELETE   = 3'd2;
    localparam logic [2:0] FN_DEL_LAST = 3'd3;
    localparam logic [2:0] FN_READ     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   cnt;
        logic signed [31:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/array_list_insert_delete.sv =====
// top level of the ordered list with insert, append, delete and read
`timescale 1ns / 1ps

// ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// request channel: req_valid / req_stall with func, position, value.
// response channel: rsp_valid / rsp_stall with read_value, length_now, status.
// every request gives exactly one response word, in the cycle after it is taken.
// each cell takes its own entry, its lower neighbor's, its upper neighbor's or
// the new value, so an insert or delete shifts the whole list in one update; the
// block takes one request per cycle while req_stall is low.
// the response sits in an output register; the next request is taken while
// the response is being taken in the same cycle, and req_stall is raised only
// while a response waits under rsp_stall.
// reset clears the length to zero and drops any pending response; entry
// contents are not cleared, only slots below the length are ever read.
// rejected requests leave the list unchanged and report full, empty or
// position out of range; unknown func codes report ok and change nothing.
module array_list_insert_delete (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         func,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] read_value,
    output logic [4:0]         length_now,
    output logic [1:0]         status
);
    import ali_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic signed [31:0] read_value_reg;
    logic signed [31:0] read_value_next;
    logic [4:0]         length_reg;
    logic [4:0]         length_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    logic               accept;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   cnt_after;
    logic               full;
    logic               empty;
    logic signed [31:0] rd_data;
    logic [1:0]         st;
    logic               do_ins;
    logic               do_del;
    logic               do_drop;
    logic [CMP_W-1:0]   ins_pos;
    cell_ctl_t          ctl;
    logic signed [31:0] cell_data [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (cnt_ext == CMP_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        st      = ST_OK;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_drop = 1'b0;
        ins_pos = pos_ext;
        rd_data = '0;
        unique case (func)
            FN_INSERT:
            begin
                if (full)
                    st = ST_FULL;
                else if (pos_ext > cnt_ext)
                    st = ST_RANGE;
                else
                    do_ins = 1'b1;
            end
            FN_APPEND:
            begin
                ins_pos = cnt_ext;
                if (full)
                    st = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            FN_DELETE:
            begin
                if (empty)
                    st = ST_EMPTY;
                else if (pos_ext >= cnt_ext)
                    st = ST_RANGE;
                else
                    do_del = 1'b1;
            end
            FN_DEL_LAST:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                    do_drop = 1'b1;
            end
            FN_READ:
            begin
                if (pos_ext >= cnt_ext)
                    st = ST_RANGE;
                else
                    rd_data = cell_data[pos_ext[IDX_W-1:0]];
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        ctl.ins   = accept && do_ins;
        ctl.del   = accept && do_del;
        ctl.pos   = ins_pos;
        ctl.cnt   = cnt_ext;
        ctl.value = value;
    end

    always_comb
    begin
        cnt_after = cnt_ext;
        if (do_ins)
            cnt_after = cnt_ext + CMP_W'(1);
        else if (do_del || do_drop)
            cnt_after = cnt_ext - CMP_W'(1);
    end

    always_comb
    begin
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        read_value_next = read_value_reg;
        length_next     = length_reg;
        status_next     = status_reg;
        if (accept)
        begin
            count_next      = cnt_after[CNT_W-1:0];
            rsp_valid_next  = 1'b1;
            read_value_next = rd_data;
            length_next     = cnt_after[4:0];
            status_next     = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        length_reg     <= length_next;
        status_reg     <= status_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        ali_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign length_now = length_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/ali_cell.sv =====
// one list slot: holds an entry and moves it up or down with its neighbors
`timescale 1ns / 1ps

module ali_cell (
    input  logic                    clk,
    input  logic [ali_pkg::IDX_W-1:0] idx,
    input  ali_pkg::cell_ctl_t      ctl,
    input  logic signed [31:0]      left_data,
    input  logic signed [31:0]      right_data,
    output logic signed [31:0]      data
);
    import ali_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   idx_inc;

    assign idx_ext = CMP_W'(idx);
    assign idx_inc = idx_ext + CMP_W'(1);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (idx_ext == ctl.pos)
                data_next = ctl.value;
            else if (idx_ext > ctl.pos && idx_ext <= ctl.cnt)
                data_next = left_data;
        end
        else if (ctl.del)
        begin
            // slots from the deleted one up to the second last pull from above
            if (idx_ext >= ctl.pos && idx_inc < ctl.cnt)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
